@@ rtl/brb_pkg.sv @@
// Shared types and constants for the byte ring buffer with block writes.
// Field widths, result status codes and the default buffer depth.
// No dependencies.
package brb_pkg;

  // Default number of byte slots in the ring
  localparam int DEPTH_DEF = 64;

  // Payload field widths
  localparam int DATA_W   = 8;
  localparam int LEN_W    = 6;
  localparam int CAP_W    = 7;
  localparam int COUNT_W  = 6;
  localparam int STATUS_W = 3;

  // Most results one read request may return
  localparam logic [COUNT_W-1:0] MAX_READ = COUNT_W'(63);

  // Item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_READ_DATA = 3'd0,
    ST_WR_OK     = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_TOO_SMALL = 3'd4
  } status_t;

endpackage

@@ rtl/brb_if.sv @@
// Stream channel interfaces: input items and result items, valid/ready.
// Depends on brb_pkg for field widths and the status type.
interface brb_in_if;
  import brb_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [DATA_W-1:0] data_in;
  logic [LEN_W-1:0]  block_len;
  logic              block_first;
  logic              block_last;
  logic [CAP_W-1:0]  out_capacity;

  modport source (output valid, kind, data_in, block_len, block_first, block_last,
                  out_capacity, input ready);
  modport sink   (input valid, kind, data_in, block_len, block_first, block_last,
                  out_capacity, output ready);
endinterface

interface brb_out_if;
  import brb_pkg::*;

  logic               valid;
  logic               ready;
  status_t            status;
  logic [DATA_W-1:0]  data_out;
  logic [COUNT_W-1:0] byte_count;
  logic               last;

  modport source (output valid, status, data_out, byte_count, last, input ready);
  modport sink   (input valid, status, data_out, byte_count, last, output ready);
endinterface

@@ rtl/brb_ram.sv @@
// Byte store of the ring: one write port, one read port, read data registered.
// Depends on brb_pkg for the data width.
module brb_ram #(
  parameter int DEPTH = brb_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [brb_pkg::DATA_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [brb_pkg::DATA_W-1:0] rd_data
);
  import brb_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, read data registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/byte_ring_buffer_block_write.sv @@
// Byte ring buffer with whole-block writes and drain-all reads.
// Depends on brb_pkg, brb_in_if / brb_out_if and brb_ram.
//
//   channel | dir | transfer                        | payload
//   in_ch   | in  | valid & ready at rising clk     | kind, data_in, block_len,
//           |     |                                 | block_first, block_last, out_capacity
//   out_ch  | out | valid & ready at rising clk     | status, data_out, byte_count, last
//
// Write bytes stream back to back while results drain. A data read enters the
// drain state and fetches bytes from the store's single read port, through the
// registered read data, to the output register: one byte per cycle while the
// output is taken. Input is held off during a drain and while the output
// register is full and not being taken. Reset is synchronous, active low; the
// store needs no clearing since only published entries are ever read.
module byte_ring_buffer_block_write #(
  parameter int DEPTH = brb_pkg::DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  brb_in_if.sink     in_ch,
  brb_out_if.source  out_ch
);
  import brb_pkg::*;

  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = ((AW > LEN_W) ? AW : LEN_W) + 1;   // fill check width
  localparam int RW  = (AW > CAP_W) ? AW : CAP_W;          // capacity compare width
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  typedef enum logic {S_IDLE, S_DRAIN} state_t;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == LAST_ADDR) ? '0 : p + AW'(1);
  endfunction

  // Registers
  state_t             state_r, state_nxt;
  logic [AW-1:0]      read_ptr_r, read_ptr_nxt;
  logic [AW-1:0]      write_ptr_r, write_ptr_nxt;
  logic [AW-1:0]      stage_ptr_r, stage_ptr_nxt;
  logic               block_ok_r, block_ok_nxt;
  logic [AW-1:0]      rd_addr_r, rd_addr_nxt;
  logic [COUNT_W-1:0] n_r, n_nxt;
  logic [COUNT_W-1:0] issued_r, issued_nxt;
  logic [COUNT_W-1:0] sent_r, sent_nxt;
  logic               mq_valid_r, mq_valid_nxt;
  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [DATA_W-1:0]  out_data_r, out_data_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;
  logic               out_last_r, out_last_nxt;

  // Store ports
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic               rd_en;
  logic [DATA_W-1:0]  rd_data;

  // Fill level and checks
  logic [AW:0]        diff;
  logic [AW-1:0]      filled;
  logic               fits;
  logic               too_small;
  logic               out_free;
  logic               in_ready;
  logic               accept;

  brb_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_ch.data_in),
    .rd_en   (rd_en),
    .rd_addr (rd_addr_r),
    .rd_data (rd_data)
  );

  // Filled count: write minus read, modulo DEPTH
  always_comb begin
    diff = {1'b0, write_ptr_r} - {1'b0, read_ptr_r};
    if (diff[AW]) begin
      filled = AW'(diff + (AW+1)'(DEPTH));
    end else begin
      filled = diff[AW-1:0];
    end
    fits      = (CW'(filled) + CW'(in_ch.block_len)) <= CW'(DEPTH - 1);
    too_small = (RW'(filled) > RW'(in_ch.out_capacity)) ||
                (RW'(filled) > RW'(MAX_READ));
  end

  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign accept   = in_ch.valid && in_ready;

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.data_out   = out_data_r;
  assign out_ch.byte_count = out_count_r;
  assign out_ch.last       = out_last_r;

  // Next-state logic
  always_comb begin
    logic [AW-1:0] sp;
    logic [AW-1:0] sp_inc;
    logic          ok;
    logic          move;
    logic          issue;

    state_nxt      = state_r;
    read_ptr_nxt   = read_ptr_r;
    write_ptr_nxt  = write_ptr_r;
    stage_ptr_nxt  = stage_ptr_r;
    block_ok_nxt   = block_ok_r;
    rd_addr_nxt    = rd_addr_r;
    n_nxt          = n_r;
    issued_nxt     = issued_r;
    sent_nxt       = sent_r;
    mq_valid_nxt   = mq_valid_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;
    wr_en          = 1'b0;
    rd_en          = 1'b0;

    sp     = in_ch.block_first ? write_ptr_r : stage_ptr_r;
    ok     = in_ch.block_first ? fits : block_ok_r;
    sp_inc = ptr_inc(sp);
    wr_addr = sp;
    move   = 1'b0;
    issue  = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_ch.kind == KIND_WRITE) begin
            // Stage the byte unless it would fill the guard slot
            if (ok) begin
              if (sp_inc == read_ptr_r) begin
                ok = 1'b0;
              end else begin
                wr_en = 1'b1;
                sp    = sp_inc;
              end
            end
            stage_ptr_nxt = sp;
            block_ok_nxt  = ok;
            // Publish the block on its last byte
            if (in_ch.block_last) begin
              if (ok) begin
                write_ptr_nxt = sp;
              end
              block_ok_nxt   = 1'b0;
              out_valid_nxt  = 1'b1;
              out_status_nxt = ok ? ST_WR_OK : ST_OVERFLOW;
              out_data_nxt   = '0;
              out_count_nxt  = '0;
              out_last_nxt   = 1'b1;
            end
          end else begin
            if (filled == '0) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_EMPTY;
              out_data_nxt   = '0;
              out_count_nxt  = '0;
              out_last_nxt   = 1'b1;
            end else if (too_small) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_TOO_SMALL;
              out_data_nxt   = '0;
              out_count_nxt  = '0;
              out_last_nxt   = 1'b1;
            end else begin
              state_nxt    = S_DRAIN;
              rd_addr_nxt  = read_ptr_r;
              n_nxt        = COUNT_W'(filled);
              issued_nxt   = '0;
              sent_nxt     = '0;
              mq_valid_nxt = 1'b0;
            end
          end
        end
      end

      S_DRAIN: begin
        // Move fetched byte to the output register
        move  = mq_valid_r && out_free;
        // Fetch the next byte when the read data register is free
        issue = (issued_r != n_r) && (!mq_valid_r || move);
        if (issue) begin
          rd_en       = 1'b1;
          rd_addr_nxt = ptr_inc(rd_addr_r);
          issued_nxt  = issued_r + COUNT_W'(1);
        end
        mq_valid_nxt = issue || (mq_valid_r && !move);
        if (move) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_READ_DATA;
          out_data_nxt   = rd_data;
          out_count_nxt  = n_r;
          out_last_nxt   = (sent_r + COUNT_W'(1)) == n_r;
          sent_nxt       = sent_r + COUNT_W'(1);
          if ((sent_r + COUNT_W'(1)) == n_r) begin
            read_ptr_nxt = write_ptr_r;
            state_nxt    = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      read_ptr_r  <= '0;
      write_ptr_r <= '0;
      stage_ptr_r <= '0;
      block_ok_r  <= 1'b0;
      mq_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      issued_r    <= '0;
      sent_r      <= '0;
      n_r         <= '0;
      rd_addr_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      read_ptr_r  <= read_ptr_nxt;
      write_ptr_r <= write_ptr_nxt;
      stage_ptr_r <= stage_ptr_nxt;
      block_ok_r  <= block_ok_nxt;
      mq_valid_r  <= mq_valid_nxt;
      out_valid_r <= out_valid_nxt;
      issued_r    <= issued_nxt;
      sent_r      <= sent_nxt;
      n_r         <= n_nxt;
      rd_addr_r   <= rd_addr_nxt;
    end
  end

  // Result payload, no reset
  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule
